// ===== rtl/bpnf_pkg.sv =====
// Shared types and constants of the bad pixel neighbor fix block.
`default_nettype none
package bpnf_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd2048;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1024;

  // Sum of up to eight 31-bit values.
  localparam int SUM_W = 34;

  typedef struct packed {
    logic        drain;
    logic [31:0] pixel;
  } item_t;

  typedef struct packed {
    logic [30:0] corrected_value;
    logic        was_replaced;
    logic        no_valid_neighbor;
    logic        last_of_frame;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_CHK,
    ST_NB_RD,
    ST_NB_ACC,
    ST_DIV,
    ST_EMIT,
    ST_PUSH
  } back_state_t;

  function automatic logic pix_valid(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bad_pixel_neighbor_fix.sv =====
// Top level of the streaming bad pixel correction block with a 3x3 neighbor mean.
`default_nettype none
// Pixels arrive in raster order; a positive value is good, anything else (gap
// or bad) is replaced by the truncated mean of the good pixels around it. A
// result leaves one row plus one pixel after its pixel, so drain items
// (in_func = 1) flush the tail; a drain with nothing pending gives no result.
// The time to release a pixel that needs repair is set by the nine-position
// neighbor scan through the single read port of the ring memory (a read
// state and an accumulate state per position) and the 34-step bit-serial
// divider; a repaired pixel with no good neighbor skips the divider. A
// result may also wait for the result register to drain. A two-entry queue
// in front of the engine keeps accepting transfers while the engine works,
// until both of its entries are full, and the result register lets the
// engine go on while a result waits. The ring memory holds 2*MAX_WIDTH+2
// words and needs no clearing pass. Writing either geometry register (while
// idle) restarts the stream position and discards pending pixels.
module bad_pixel_neighbor_fix
  import bpnf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [31:0]           in_pixel_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [30:0]                out_corrected_value,
  output logic                       out_was_replaced,
  output logic                       out_no_valid_neighbor,
  output logic                       out_last_of_frame,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]           cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [11:0]   fwidth_r;
  logic [15:0]   fheight_r;
  logic          cfg_write, clear;
  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic          q_valid, q_ready;
  item_t         q_item;
  res_t          res;

  // Configuration writes always complete in one transfer.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    clear = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: clear = 1'b1;
        default:                           clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r  <= FRAME_WIDTH_RESET;
      fheight_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_FRAME_WIDTH)  fwidth_r  <= cfg_data[11:0];
      if (cfg_index == CFG_FRAME_HEIGHT) fheight_r <= cfg_data;
    end
  end

  // A width of zero acts as one and a width above the ring size is clipped.
  always_comb begin
    if (fwidth_r == 12'd0) eff_w = WW'(1);
    else if (32'(fwidth_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(fwidth_r);
    eff_h = (fheight_r == 16'd0) ? 16'd1 : fheight_r;
  end

  bpnf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_pixel_value (in_pixel_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_ready        (q_ready)
  );

  bpnf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_corrected_value   = res.corrected_value;
  assign out_was_replaced      = res.was_replaced;
  assign out_no_valid_neighbor = res.no_valid_neighbor;
  assign out_last_of_frame     = res.last_of_frame;

`ifndef SYNTHESIS
  // A pixel without good neighbors is always a replaced pixel forced to zero.
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_valid_neighbor |-> out_was_replaced && out_corrected_value == 31'd0)
    else $error("no_valid_neighbor result is not a replaced zero");

  // A pixel that passed unchanged must have been a good (nonzero) value.
  a_pass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_replaced |-> out_corrected_value != 31'd0)
    else $error("unreplaced result is zero");
`endif

endmodule
`default_nettype wire

// ===== rtl/bpnf_front.sv =====
// Input stage: accepts items and queues them for the correction engine.
`default_nettype none
module bpnf_front
  import bpnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [31:0] in_pixel_value,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_ready
);

  item_t       q_mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{drain: in_func, pixel: in_pixel_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bpnf_back.sv =====
// Correction engine: pixel ring memory, neighbor scan, mean divider, result register.
`default_nettype none
module bpnf_back
  import bpnf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             clear,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  input  wire logic [15:0]                      eff_h,
  input  wire logic                             q_valid,
  input  wire item_t                            q_item,
  output logic                                  q_ready,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output res_t                                  out_res
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 3);
  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

  logic [31:0] ring [DEPTH];
  logic [31:0] rdata_r;

  back_state_t        state_r, state_nxt;
  logic [PW-1:0]      pend_r, pend_nxt;
  logic [AW-1:0]      oldest_r, oldest_nxt;
  logic [WW-1:0]      ocol_r, ocol_nxt;
  logic [15:0]        orow_r, orow_nxt;
  logic [3:0]         k_r, k_nxt;
  logic               inc_r, inc_nxt;
  logic [SUM_W-1:0]   dq_r, dq_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [5:0]         step_r, step_nxt;
  logic [30:0]        val_r, val_nxt;
  logic               rep_r, rep_nxt;
  logic               none_r, none_nxt;
  logic [31:0]        hold_r, hold_nxt;
  logic               has_in_r, has_in_nxt;
  logic               use_hold_r, use_hold_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata;

  logic [1:0]         dy_i, dx_i;
  logic               in_bounds, fwd, include_k, use_hold;
  logic [PW:0]        dpos, dneg;
  logic [AW:0]        a_fwd, a_bwd, a_wr;
  logic [PW:0]        pend_ext, w_plus1;
  logic [4:0]         rem_t;
  logic [30:0]        emit_val;
  logic [31:0]        nb_val;

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= ring[mem_raddr];
  end

  always_comb begin
    unique case (k_r)
      4'd0, 4'd1, 4'd2: dy_i = 2'd0;
      4'd3, 4'd4, 4'd5: dy_i = 2'd1;
      default:          dy_i = 2'd2;
    endcase
    case (k_r)
      4'd0, 4'd3, 4'd6: dx_i = 2'd0;
      4'd1, 4'd4, 4'd7: dx_i = 2'd1;
      default:          dx_i = 2'd2;
    endcase
    in_bounds = !(dx_i == 2'd0 && ocol_r == '0) &&
                !(dx_i == 2'd2 && ocol_r == eff_w - WW'(1)) &&
                !(dy_i == 2'd0 && orow_r == 16'd0) &&
                !(dy_i == 2'd2 && orow_r == eff_h - 16'd1);
    fwd  = (dy_i == 2'd2) || (dy_i == 2'd1 && dx_i == 2'd2);
    dpos = ((dy_i == 2'd2) ? (PW+1)'(eff_w) : '0) + ((dx_i == 2'd2) ? (PW+1)'(1) : '0)
           - ((dx_i == 2'd0) ? (PW+1)'(1) : '0);
    dneg = ((dy_i == 2'd0) ? (PW+1)'(eff_w) : '0) + ((dx_i == 2'd0) ? (PW+1)'(1) : '0)
           - ((dx_i == 2'd2) ? (PW+1)'(1) : '0);
    pend_ext  = (PW+1)'(pend_r);
    // The neighbor just past the newest stored pixel is the held incoming one.
    use_hold  = fwd && has_in_r && (dpos == pend_ext);
    include_k = (k_r != 4'd4) && in_bounds && (!fwd || (dpos < pend_ext) || use_hold);
    a_fwd = (AW+1)'(oldest_r) + (AW+1)'(dpos);
    if (a_fwd >= DEPTH_V) a_fwd = a_fwd - DEPTH_V;
    if ((AW+1)'(oldest_r) >= (AW+1)'(dneg)) a_bwd = (AW+1)'(oldest_r) - (AW+1)'(dneg);
    else a_bwd = (AW+1)'(oldest_r) + DEPTH_V - (AW+1)'(dneg);
    a_wr = (AW+1)'(oldest_r) + (AW+1)'(pend_r);
    if (a_wr >= DEPTH_V) a_wr = a_wr - DEPTH_V;
    w_plus1 = (PW+1)'(eff_w) + (PW+1)'(1);
    rem_t = {rem_r, dq_r[SUM_W-1]};
    emit_val = (rep_r && !none_r) ? dq_r[30:0] : val_r;
    nb_val = use_hold_r ? hold_r : rdata_r;
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    oldest_nxt    = oldest_r;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    k_nxt         = k_r;
    inc_nxt       = inc_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    val_nxt       = val_r;
    rep_nxt       = rep_r;
    none_nxt      = none_r;
    hold_nxt      = hold_r;
    has_in_nxt    = has_in_r;
    use_hold_nxt  = use_hold_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = oldest_r;
    mem_wdata     = q_item.pixel;
    mem_re        = 1'b0;
    mem_raddr     = oldest_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.drain) begin
            has_in_nxt = 1'b0;
            if (pend_r != '0) state_nxt = ST_CTR_RD;
          end else if (pend_ext >= w_plus1) begin
            // The new pixel waits in a register until the oldest one is out,
            // because its ring slot may still be read by the neighbor scan.
            hold_nxt   = q_item.pixel;
            has_in_nxt = 1'b1;
            state_nxt  = ST_CTR_RD;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = a_wr[AW-1:0];
            pend_nxt  = pend_r + PW'(1);
          end
        end
      end
      ST_CTR_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_CTR_CHK;
      end
      ST_CTR_CHK: begin
        if (pix_valid(rdata_r)) begin
          val_nxt   = rdata_r[30:0];
          rep_nxt   = 1'b0;
          none_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          dq_nxt    = '0;
          cnt_nxt   = 4'd0;
          k_nxt     = 4'd0;
          state_nxt = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        mem_re       = include_k && !use_hold;
        mem_raddr    = fwd ? a_fwd[AW-1:0] : a_bwd[AW-1:0];
        inc_nxt      = include_k;
        use_hold_nxt = use_hold;
        state_nxt    = ST_NB_ACC;
      end
      ST_NB_ACC: begin
        if (inc_r && pix_valid(nb_val)) begin
          dq_nxt  = dq_r + SUM_W'(nb_val[30:0]);
          cnt_nxt = cnt_r + 4'd1;
        end
        if (k_r == 4'd8) begin
          rep_nxt = 1'b1;
          if (cnt_nxt == 4'd0) begin
            val_nxt   = '0;
            none_nxt  = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            none_nxt  = 1'b0;
            rem_nxt   = 4'd0;
            step_nxt  = 6'd0;
            state_nxt = ST_DIV;
          end
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_NB_RD;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_t >= {1'b0, cnt_r}) begin
          rem_nxt = 4'(rem_t - {1'b0, cnt_r});
          dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_t[3:0];
          dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SUM_W - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt.corrected_value   = emit_val;
          out_res_nxt.was_replaced      = rep_r;
          out_res_nxt.no_valid_neighbor = none_r;
          out_res_nxt.last_of_frame     = (ocol_r == eff_w - WW'(1)) &&
                                          (orow_r == eff_h - 16'd1);
          mem_we    = rep_r;
          mem_waddr = oldest_r;
          mem_wdata = {1'b0, emit_val};
          if (ocol_r == eff_w - WW'(1)) begin
            ocol_nxt = '0;
            orow_nxt = (orow_r == eff_h - 16'd1) ? 16'd0 : orow_r + 16'd1;
          end else begin
            ocol_nxt = ocol_r + WW'(1);
          end
          oldest_nxt = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + AW'(1);
          pend_nxt   = pend_r - PW'(1);
          state_nxt  = has_in_r ? ST_PUSH : ST_IDLE;
        end
      end
      ST_PUSH: begin
        // The held pixel now goes in behind the newest stored one.
        mem_we    = 1'b1;
        mem_waddr = a_wr[AW-1:0];
        mem_wdata = hold_r;
        pend_nxt  = pend_r + PW'(1);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      oldest_r    <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear) begin
        pend_r   <= '0;
        oldest_r <= '0;
        ocol_r   <= '0;
        orow_r   <= '0;
      end else begin
        pend_r   <= pend_nxt;
        oldest_r <= oldest_nxt;
        ocol_r   <= ocol_nxt;
        orow_r   <= orow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    inc_r      <= inc_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    val_r      <= val_nxt;
    rep_r      <= rep_nxt;
    none_r     <= none_nxt;
    hold_r     <= hold_nxt;
    has_in_r   <= has_in_nxt;
    use_hold_r <= use_hold_nxt;
    out_res_r  <= out_res_nxt;
  end

endmodule
`default_nettype wire
